>>> design/blg_pkg.sv
// Package for the bit-packed life generation unit.
// Holds command and register codes, reset values and the B3/S23 cell rule.
// No dependencies.
package blg_pkg;

  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_PAGES_DEF   = 8;

  localparam int CMD_W  = 2;
  localparam int COL_W  = 7;
  localparam int PAGE_W = 3;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int COLS_REG_W  = 8;
  localparam int PAGES_REG_W = 4;

  localparam logic [COLS_REG_W-1:0]  COLUMNS_RESET = 8'd84;
  localparam logic [PAGES_REG_W-1:0] PAGES_RESET   = 4'd6;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GEN    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INVERT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES   = 2'd1;

  localparam int LOW_CELL_BIT = 7;
  localparam int TOP_CELL_BIT = 0;

  typedef struct packed {
    logic clear;      // zero the column window at the start of a generation
    logic shift;      // move the incoming column one cell down the chain
    logic commit;     // west <= center <= east <= incoming
    logic capture;    // latch the new bytes of the center column
    logic res_shift;  // move the new bytes one cell toward cell zero
  } blg_cell_ctrl_t;

  // New byte of one page column. Edge bits are ordered {west, center, east}.
  function automatic logic [BYTE_W-1:0] life_byte(
    input logic [BYTE_W-1:0] w,
    input logic [BYTE_W-1:0] cur,
    input logic [BYTE_W-1:0] e,
    input logic [2:0]        up_bits,
    input logic [2:0]        dn_bits
  );
    logic [BYTE_W-1:0] nb [8];
    logic [BYTE_W-1:0] res;
    logic [3:0]        cnt;
    nb[0] = w;
    nb[1] = e;
    nb[2] = {cur[6:0], up_bits[1]};
    nb[3] = {w[6:0], up_bits[2]};
    nb[4] = {e[6:0], up_bits[0]};
    nb[5] = {dn_bits[1], cur[7:1]};
    nb[6] = {dn_bits[2], w[7:1]};
    nb[7] = {dn_bits[0], e[7:1]};
    res = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      cnt = '0;
      for (int n = 0; n < 8; n++) begin
        cnt = cnt + 4'(nb[n][k]);
      end
      res[k] = (cnt == 4'd3) || ((cnt == 4'd2) && cur[k]);
    end
    return res;
  endfunction

endpackage

>>> design/blg_intf.sv
// Handshake channel interfaces of the bit-packed life generation unit.
// Depends on blg_pkg for the field widths.
interface blg_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [blg_pkg::CMD_W-1:0]    command;
  logic [blg_pkg::COL_W-1:0]    column;
  logic [blg_pkg::PAGE_W-1:0]   page;
  logic [blg_pkg::BYTE_W-1:0]   write_data;
  modport source(output valid, command, column, page, write_data, input ready);
  modport sink(input valid, command, column, page, write_data, output ready);
endinterface

interface blg_res_if;
  logic                         valid;
  logic                         ready;
  logic [blg_pkg::BYTE_W-1:0]   read_data;
  logic [blg_pkg::CMD_W-1:0]    done_command;
  modport source(output valid, read_data, done_command, input ready);
  modport sink(input valid, read_data, done_command, output ready);
endinterface

interface blg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [blg_pkg::CFG_IDX_W-1:0]    index;
  logic [blg_pkg::CFG_DATA_W-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> design/bitpacked_life_generation_unit.sv
// Top level of the bit-packed life generation unit (rule B3/S23).
// Depends on blg_pkg, the channel interfaces, blg_mem and blg_cell.
//
// Commands arrive on cmd_i, one result per command leaves on res_o, and the
// grid size registers are written on cfg_i (index 0 columns, 1 pages). A
// transfer happens on a rising edge with valid and ready both high.
// After reset a clearing pass writes zero to every grid byte; cmd_i is not
// ready during it, cfg_i is. One command is worked on at a time. Invert
// reads one byte a cycle from the single read port of the grid memory, and
// a generation loads each column into a chain of page cells one byte a
// cycle, then shifts the window and computes. The result sits in an output
// register, so a stalled receiver only holds the unit after it has
// finished the next command.
module bitpacked_life_generation_unit #(
  parameter int MAX_COLUMNS = blg_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_PAGES   = blg_pkg::MAX_PAGES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  blg_cfg_if.sink   cfg_i,
  blg_cmd_if.sink   cmd_i,
  blg_res_if.source res_o
);
  import blg_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int JW    = $clog2(MAX_COLUMNS + 2);
  localparam int PCW   = $clog2(MAX_PAGES + 1);
  localparam int IW    = $clog2(MAX_PAGES + 2);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_GEN   = 3'd3;
  localparam logic [2:0] ST_INV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  function automatic logic [AW-1:0] addr_of(input int p, input int c);
    return AW'(p * MAX_COLUMNS + c);
  endfunction

  logic [2:0]             state_q, state_d;
  logic [COLS_REG_W-1:0]  cols_q;
  logic [PAGES_REG_W-1:0] pages_q;
  logic [AW-1:0]          clr_q, clr_d;
  logic [CMD_W-1:0]       cmd_q, cmd_d;
  logic                   rd_ok_q, rd_ok_d;
  logic [BYTE_W-1:0]      rd_q, rd_d;
  logic                   out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]      out_rd_q, out_rd_d;
  logic [CMD_W-1:0]       out_cmd_q, out_cmd_d;
  logic [IW-1:0]          gi_q, gi_d;
  logic [JW-1:0]          gj_q, gj_d;
  logic [PCW-1:0]         ip_q, ip_d;
  logic [CW-1:0]          ic_q, ic_d;
  logic                   inv_run_q, inv_run_d;
  logic                   inv_wv_q, inv_wv_d;
  logic [AW-1:0]          inv_wa_q, inv_wa_d;

  logic [CW-1:0]     used_c;
  logic [PCW-1:0]    used_p;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;
  logic              cmd_take, cmd_inside;
  logic [BYTE_W-1:0] shift_data;
  blg_cell_ctrl_t    cell_ctrl;

  logic [BYTE_W-1:0] inc_w [MAX_PAGES];
  logic [BYTE_W-1:0] res_w [MAX_PAGES];
  logic [2:0]        top_w [MAX_PAGES];
  logic [2:0]        bot_w [MAX_PAGES];

  // Register values above the memory size are taken as the memory size.
  assign used_c = (int'(cols_q) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(cols_q);
  assign used_p = (int'(pages_q) > MAX_PAGES) ? PCW'(MAX_PAGES) : PCW'(pages_q);

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_take    = cmd_i.valid && cmd_i.ready;
  assign cmd_inside  = (int'(cmd_i.column) < MAX_COLUMNS) && (int'(cmd_i.page) < MAX_PAGES);

  assign res_o.valid        = out_valid_q;
  assign res_o.read_data    = out_rd_q;
  assign res_o.done_command = out_cmd_q;

  // Columns beyond the used width load as dead cells.
  assign shift_data = (int'(gj_q) < int'(used_c)) ? mem_rdata : '0;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    rd_ok_d     = rd_ok_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q;
    out_rd_d    = out_rd_q;
    out_cmd_d   = out_cmd_q;
    gi_d        = gi_q;
    gj_d        = gj_q;
    ip_d        = ip_q;
    ic_d        = ic_q;
    inv_run_d   = inv_run_q;
    inv_wv_d    = inv_wv_q;
    inv_wa_d    = inv_wa_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    cell_ctrl   = '0;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_take) begin
          cmd_d   = cmd_i.command;
          rd_ok_d = cmd_inside;
          rd_d    = '0;
          unique case (cmd_i.command)
            CMD_WRITE: begin
              mem_we    = cmd_inside;
              mem_waddr = addr_of(int'(cmd_i.page), int'(cmd_i.column));
              mem_wdata = cmd_i.write_data;
              state_d   = ST_DONE;
            end
            CMD_READ: begin
              mem_raddr = addr_of(int'(cmd_i.page), int'(cmd_i.column));
              state_d   = ST_READ;
            end
            CMD_GEN: begin
              cell_ctrl.clear = 1'b1;
              gi_d    = '0;
              gj_d    = '0;
              state_d = (used_c == '0 || used_p == '0) ? ST_DONE : ST_GEN;
            end
            default: begin
              ip_d      = '0;
              ic_d      = '0;
              inv_run_d = 1'b1;
              inv_wv_d  = 1'b0;
              state_d   = (used_c == '0 || used_p == '0) ? ST_DONE : ST_INV;
            end
          endcase
        end
      end
      ST_READ: begin
        rd_d    = rd_ok_q ? mem_rdata : '0;
        state_d = ST_DONE;
      end
      ST_GEN: begin
        // Phase of column gj: read it page by page from the last page down,
        // shift it into the chain, write back the new bytes of column gj-2,
        // then commit the window.
        cell_ctrl.capture = (gi_q == '0) && (int'(gj_q) >= 2);
        if (int'(gi_q) < int'(used_p) && int'(gj_q) < int'(used_c)) begin
          mem_raddr = addr_of(int'(used_p) - 1 - int'(gi_q), int'(gj_q));
        end
        if (gi_q != '0 && int'(gi_q) <= int'(used_p)) begin
          cell_ctrl.shift = 1'b1;
          if (int'(gj_q) >= 2) begin
            cell_ctrl.res_shift = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = addr_of(int'(gi_q) - 1, int'(gj_q) - 2);
            mem_wdata = res_w[0];
          end
        end
        if (int'(gi_q) == int'(used_p) + 1) begin
          cell_ctrl.commit = 1'b1;
          gi_d = '0;
          gj_d = gj_q + 1'b1;
        end else begin
          gi_d = gi_q + 1'b1;
        end
        if (int'(gj_q) == int'(used_c) + 1 && int'(gi_q) == int'(used_p)) begin
          state_d = ST_DONE;
        end
      end
      ST_INV: begin
        mem_we    = inv_wv_q;
        mem_waddr = inv_wa_q;
        mem_wdata = ~mem_rdata;
        if (inv_run_q) begin
          mem_raddr = addr_of(int'(ip_q), int'(ic_q));
          inv_wa_d  = addr_of(int'(ip_q), int'(ic_q));
          inv_wv_d  = 1'b1;
          if (int'(ic_q) == int'(used_c) - 1) begin
            ic_d = '0;
            ip_d = ip_q + 1'b1;
            if (int'(ip_q) == int'(used_p) - 1) begin
              inv_run_d = 1'b0;
            end
          end else begin
            ic_d = ic_q + 1'b1;
          end
        end else begin
          inv_wv_d = 1'b0;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_rd_d    = rd_q;
          out_cmd_d   = cmd_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cols_q      <= COLUMNS_RESET;
      pages_q     <= PAGES_RESET;
      out_valid_q <= 1'b0;
      inv_run_q   <= 1'b0;
      inv_wv_q    <= 1'b0;
      gi_q        <= '0;
      gj_q        <= '0;
      ip_q        <= '0;
      ic_q        <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      inv_run_q   <= inv_run_d;
      inv_wv_q    <= inv_wv_d;
      gi_q        <= gi_d;
      gj_q        <= gj_d;
      ip_q        <= ip_d;
      ic_q        <= ic_d;
      if (cfg_i.valid) begin
        if (cfg_i.index == CFG_COLUMNS) begin
          cols_q <= cfg_i.data;
        end else if (cfg_i.index == CFG_PAGES) begin
          pages_q <= cfg_i.data[PAGES_REG_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    rd_ok_q   <= rd_ok_d;
    rd_q      <= rd_d;
    out_rd_q  <= out_rd_d;
    out_cmd_q <= out_cmd_d;
    inv_wa_q  <= inv_wa_d;
  end

  blg_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Chain of page cells: the incoming column moves toward higher pages, the
  // new bytes move toward page zero, where they are written back.
  for (genvar k = 0; k < MAX_PAGES; k++) begin : g_cell
    logic [BYTE_W-1:0] inc_in, res_in;
    logic [2:0]        up_in, dn_in;

    if (k == 0) begin : g_first
      assign inc_in = shift_data;
      assign up_in  = '0;
    end else begin : g_inner
      assign inc_in = inc_w[k-1];
      assign up_in  = bot_w[k-1];
    end

    if (k == MAX_PAGES - 1) begin : g_last
      assign res_in = '0;
      assign dn_in  = '0;
    end else begin : g_below
      assign res_in = res_w[k+1];
      // Pages beyond the used height count as dead.
      assign dn_in  = ((k + 1) < int'(used_p)) ? top_w[k+1] : 3'b000;
    end

    blg_cell u_cell (
      .clk_i (clk_i),
      .ctrl_i(cell_ctrl),
      .inc_i (inc_in),
      .res_i (res_in),
      .up_i  (up_in),
      .dn_i  (dn_in),
      .inc_o (inc_w[k]),
      .res_o (res_w[k]),
      .top_o (top_w[k]),
      .bot_o (bot_w[k])
    );
  end
endmodule

>>> design/blg_mem.sv
// Grid byte memory with one write port and one registered read port.
// Depends on blg_pkg for the byte width.
module blg_mem #(
  parameter int DEPTH = blg_pkg::MAX_COLUMNS_DEF * blg_pkg::MAX_PAGES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [blg_pkg::BYTE_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [blg_pkg::BYTE_W-1:0] rdata_o
);
  import blg_pkg::*;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> design/blg_cell.sv
// One page cell of the generation chain: a three-column window of one page.
// Depends on blg_pkg for the control struct and the cell rule.
module blg_cell (
  input  logic                         clk_i,
  input  blg_pkg::blg_cell_ctrl_t      ctrl_i,
  input  logic [blg_pkg::BYTE_W-1:0]   inc_i,
  input  logic [blg_pkg::BYTE_W-1:0]   res_i,
  input  logic [2:0]                   up_i,
  input  logic [2:0]                   dn_i,
  output logic [blg_pkg::BYTE_W-1:0]   inc_o,
  output logic [blg_pkg::BYTE_W-1:0]   res_o,
  output logic [2:0]                   top_o,
  output logic [2:0]                   bot_o
);
  import blg_pkg::*;

  logic [BYTE_W-1:0] inc_q, w_q, cur_q, e_q, res_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      inc_q <= inc_i;
    end
    if (ctrl_i.clear) begin
      w_q   <= '0;
      cur_q <= '0;
      e_q   <= '0;
    end else if (ctrl_i.commit) begin
      w_q   <= cur_q;
      cur_q <= e_q;
      e_q   <= inc_q;
    end
    if (ctrl_i.capture) begin
      res_q <= life_byte(w_q, cur_q, e_q, up_i, dn_i);
    end else if (ctrl_i.res_shift) begin
      res_q <= res_i;
    end
  end

  assign inc_o = inc_q;
  assign res_o = res_q;
  assign top_o = {w_q[TOP_CELL_BIT], cur_q[TOP_CELL_BIT], e_q[TOP_CELL_BIT]};
  assign bot_o = {w_q[LOW_CELL_BIT], cur_q[LOW_CELL_BIT], e_q[LOW_CELL_BIT]};
endmodule

>>> tb/sv/tb_pkg.sv
// Shared test constants and types for the bit-packed life generation unit bench.
// Depends on blg_pkg; interfaces live in design/blg_intf.sv.
package tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  import blg_pkg::*;

  localparam int GRID_DEPTH = MAX_COLUMNS_DEF * MAX_PAGES_DEF;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [COL_W-1:0]  column;
    logic [PAGE_W-1:0] page;
    logic [BYTE_W-1:0] write_data;
  } life_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic [CMD_W-1:0]  done_command;
  } life_res_t;
endpackage

>>> tb/sv/tb.sv
// Self-checking bench for the bit-packed life generation unit.
// Depends on blg_pkg, tb_pkg and the channel interfaces of blg_intf.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import blg_pkg::*;
  import tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  blg_cfg_if cfg_ch();
  blg_cmd_if cmd_ch();
  blg_res_if res_ch();

  bitpacked_life_generation_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_ch.sink), .cmd_i(cmd_ch.sink),
    .res_o(res_ch.source)
  );

  // Shadow of the grid and size registers, updated as commands and register writes transfer.
  logic [BYTE_W-1:0] shadow_grid [GRID_DEPTH];
  logic [COLS_REG_W-1:0]  shadow_cols;
  logic [PAGES_REG_W-1:0] shadow_pages;

  life_cmd_t pending_cmds [$];
  life_res_t expected_results [$];
  int unsigned mismatch_count = 0;
  bit long_hold = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Byte of the in-use grid, zero beyond its edges.
  function automatic logic [BYTE_W-1:0] grid_at(input int c, input int p,
                                                input int nc, input int np);
    if (c < 0 || p < 0 || c >= nc || p >= np) return '0;
    return shadow_grid[p * MAX_COLUMNS_DEF + c];
  endfunction

  function automatic int used_cols();
    return (shadow_cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(shadow_cols);
  endfunction

  function automatic int used_pages();
    return (shadow_pages > MAX_PAGES_DEF) ? MAX_PAGES_DEF : int'(shadow_pages);
  endfunction

  task automatic step_generation();
    logic [BYTE_W-1:0] fresh [GRID_DEPTH];
    logic [BYTE_W-1:0] cur, w, e, up, upw, upe, dn, dnw, dne;
    logic [BYTE_W-1:0] nb [8];
    int nc, np, cnt;
    nc = used_cols();
    np = used_pages();
    for (int p = 0; p < np; p++) begin
      for (int c = 0; c < nc; c++) begin
        cur = grid_at(c, p, nc, np);
        w = grid_at(c - 1, p, nc, np);
        e = grid_at(c + 1, p, nc, np);
        up = grid_at(c, p - 1, nc, np);
        upw = grid_at(c - 1, p - 1, nc, np);
        upe = grid_at(c + 1, p - 1, nc, np);
        dn = grid_at(c, p + 1, nc, np);
        dnw = grid_at(c - 1, p + 1, nc, np);
        dne = grid_at(c + 1, p + 1, nc, np);
        // Vertical neighbours cross into the page above or below.
        nb[0] = w;
        nb[1] = e;
        nb[2] = {cur[6:0], up[7]};
        nb[3] = {w[6:0], upw[7]};
        nb[4] = {e[6:0], upe[7]};
        nb[5] = {dn[0], cur[7:1]};
        nb[6] = {dnw[0], w[7:1]};
        nb[7] = {dne[0], e[7:1]};
        fresh[p * MAX_COLUMNS_DEF + c] = '0;
        for (int k = 0; k < 8; k++) begin
          cnt = 0;
          for (int n = 0; n < 8; n++) cnt += nb[n][k];
          fresh[p * MAX_COLUMNS_DEF + c][k] = (cnt == 3) || (cnt == 2 && cur[k]);
        end
      end
    end
    for (int p = 0; p < np; p++)
      for (int c = 0; c < nc; c++)
        shadow_grid[p * MAX_COLUMNS_DEF + c] = fresh[p * MAX_COLUMNS_DEF + c];
  endtask

  // Applies one accepted command to the shadow and queues its result.
  task automatic predict_command(input life_cmd_t cmd);
    life_res_t res;
    int a;
    a = int'(cmd.page) * MAX_COLUMNS_DEF + int'(cmd.column);
    res.read_data = '0;
    res.done_command = cmd.command;
    case (cmd.command)
      CMD_WRITE: shadow_grid[a] = cmd.write_data;
      CMD_READ: res.read_data = shadow_grid[a];
      CMD_GEN: step_generation();
      default: begin
        for (int p = 0; p < used_pages(); p++)
          for (int c = 0; c < used_cols(); c++)
            shadow_grid[p * MAX_COLUMNS_DEF + c] = ~shadow_grid[p * MAX_COLUMNS_DEF + c];
      end
    endcase
    expected_results.push_back(res);
  endtask

  // Command driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_command({cmd_ch.command, cmd_ch.column, cmd_ch.page, cmd_ch.write_data});
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          cmd_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          life_cmd_t nxt;
          nxt = pending_cmds.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.command <= nxt.command;
          cmd_ch.column <= nxt.column;
          cmd_ch.page <= nxt.page;
          cmd_ch.write_data <= nxt.write_data;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with its own stall pattern, plus a long hold-off on request.
  int stall_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result cmd=%0d data=%02h",
                                    res_ch.done_command, res_ch.read_data));
        end else begin
          life_res_t exp_res;
          exp_res = expected_results.pop_front();
          if (res_ch.done_command !== exp_res.done_command)
            report_mismatch($sformatf("done_command %0d, expected %0d",
                                      res_ch.done_command, exp_res.done_command));
          if (res_ch.read_data !== exp_res.read_data)
            report_mismatch($sformatf("read_data %02h, expected %02h",
                                      res_ch.read_data, exp_res.read_data));
        end
      end
      stall_phase <= (stall_phase + 1) % 40;
      if (long_hold) res_ch.ready <= 1'b0;
      else if (stall_phase < 16) res_ch.ready <= 1'b1;
      else res_ch.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_COLUMNS) shadow_cols = val;
    else if (idx == CFG_PAGES) shadow_pages = val[PAGES_REG_W-1:0];
  endtask

  // Waits until every queued command has transferred and its result arrived.
  task automatic drain();
    while (pending_cmds.size() > 0 || cmd_ch.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic life_cmd_t make_cmd(input logic [CMD_W-1:0] op, input int c, input int p,
                                         input int d);
    life_cmd_t x;
    x.command = op;
    x.column = c[COL_W-1:0];
    x.page = p[PAGE_W-1:0];
    x.write_data = d[BYTE_W-1:0];
    return x;
  endfunction

  // Well-formed random phase: seed the area in use, run generations, read back.
  task automatic random_phase(input int n_items, input int nc, input int np);
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) pending_cmds.push_back(make_cmd(CMD_WRITE,
          $urandom_range(0, (nc > 0) ? nc - 1 : 127), $urandom_range(0, (np > 0) ? np - 1 : 7),
          $urandom_range(0, 255)));
      else if (r < 80) pending_cmds.push_back(make_cmd(CMD_READ,
          $urandom_range(0, 127), $urandom_range(0, 7), $urandom_range(0, 255)));
      else if (r < 94) pending_cmds.push_back(make_cmd(CMD_GEN, $urandom_range(0, 127),
          $urandom_range(0, 7), $urandom_range(0, 255)));
      else pending_cmds.push_back(make_cmd(CMD_INVERT, $urandom_range(0, 127),
          $urandom_range(0, 7), $urandom_range(0, 255)));
    end
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = '0;
    cmd_ch.column = '0;
    cmd_ch.page = '0;
    cmd_ch.write_data = '0;
    res_ch.ready = 1'b0;
    shadow_cols = COLUMNS_RESET;
    shadow_pages = PAGES_RESET;
    foreach (shadow_grid[i]) shadow_grid[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a four-cell pattern across a page border near the corner at the reset size, edge addresses.
    pending_cmds.push_back(make_cmd(CMD_READ, 127, 7, 0));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 0, 0, 8'h80));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 1, 1, 8'h01));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 2, 1, 8'h01));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 1, 0, 8'h80));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 83, 5, 8'hFF));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 127, 7, 8'h5A));
    pending_cmds.push_back(make_cmd(CMD_GEN, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 1, 1, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 83, 5, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 127, 7, 0));
    pending_cmds.push_back(make_cmd(CMD_INVERT, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 2, 1, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 127, 7, 0));
    pending_cmds.push_back(make_cmd(CMD_GEN, 127, 7, 255));
    pending_cmds.push_back(make_cmd(CMD_READ, 40, 3, 0));
    drain();

    // Long receiver hold-off while commands keep coming.
    long_hold = 1'b1;
    random_phase(30, 84, 6);
    repeat (3000) @(posedge clk_i);
    long_hold = 1'b0;
    drain();

    // Small grids, then the extremes, an unused register index and a mid-size grid.
    write_reg(CFG_COLUMNS, 8'd5);
    write_reg(CFG_PAGES, 8'd2);
    random_phase(150, 5, 2);
    drain();
    write_reg(CFG_COLUMNS, 8'd1);
    write_reg(CFG_PAGES, 8'd1);
    random_phase(50, 1, 1);
    drain();
    write_reg(CFG_COLUMNS, 8'd0);
    write_reg(CFG_PAGES, 8'd0);
    random_phase(30, 0, 0);
    drain();
    write_reg(CFG_COLUMNS, 8'd255);
    write_reg(CFG_PAGES, 8'd15);
    random_phase(60, 128, 8);
    drain();
    write_reg(CFG_COLUMNS, 8'd128);
    write_reg(CFG_PAGES, 8'd8);
    random_phase(40, 128, 8);
    drain();
    write_reg(2'd3, 8'hAA);
    write_reg(CFG_COLUMNS, 8'd12);
    write_reg(CFG_PAGES, 8'd3);
    random_phase(200, 12, 3);
    drain();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule

>>> files.f
design/blg_pkg.sv
design/blg_intf.sv
design/blg_mem.sv
design/blg_cell.sv
design/bitpacked_life_generation_unit.sv
tb/sv/tb_pkg.sv
tb/sv/tb.sv
